@@ sv/usfr_pkg.sv @@
`timescale 1ns / 1ps
// usfr_pkg: shared types and constants of the UART status frame receiver.
// No dependencies; imported by the front, queue, back and top modules.
package usfr_pkg;

  // Header bytes and their XOR, which seeds the checksum.
  localparam logic [7:0] HDR0    = 8'hBB;
  localparam logic [7:0] HDR1    = 8'h00;
  localparam logic [7:0] HDR2    = 8'h04;
  localparam logic [7:0] HDR_XOR = 8'hBF;

  // Payload positions that are captured.
  localparam logic [7:0] POS_CURRENT = 8'd0;
  localparam logic [7:0] POS_MODE    = 8'd2;
  localparam logic [7:0] POS_SPEED   = 8'd3;
  localparam logic [7:0] POS_TARGET  = 8'd26;

  localparam logic [7:0] STATUS_MIN_LEN  = 8'd32;
  localparam logic [7:0] TEMP_MIN_LEN    = 8'd4;
  localparam logic [7:0] CURRENT_MIN_RAW = 8'd7;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_STATUS_CMD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CMD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ECO_MASK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TURBO_MASK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_QUIET_MASK = 3'd4;

  localparam logic [7:0] ECO_MASK_RST   = 8'h80;
  localparam logic [7:0] TURBO_MASK_RST = 8'h40;
  localparam logic [7:0] QUIET_MASK_RST = 8'h80;

  typedef enum logic [1:0] {
    KIND_STATUS  = 2'd0,
    KIND_TEMP    = 2'd1,
    KIND_ERROR   = 2'd2,
    KIND_IGNORED = 2'd3
  } frame_kind_t;

  // Deframer phases, one-hot.
  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_CMD  = 4'b0010,
    PH_LEN  = 4'b0100,
    PH_PAY  = 4'b1000
  } phase_t;

  // One completed frame as handed from front to back.
  typedef struct packed {
    logic [7:0] command;
    logic [7:0] length;
    logic [7:0] calc_sum;
    logic [7:0] rx_sum;
    logic [7:0] mode_flags;
    logic [7:0] speed_flags;
    logic [7:0] target_byte;
    logic [7:0] current_byte;
  } frame_rec_t;

  typedef struct packed {
    logic [7:0] status_cmd;
    logic [7:0] temp_cmd;
    logic [7:0] eco_mask;
    logic [7:0] turbo_mask;
    logic [7:0] quiet_mask;
  } cfg_t;

  typedef struct packed {
    frame_kind_t kind;
    logic        eco_on;
    logic        turbo_flag;
    logic        quiet_flag;
    logic        target_valid;
    logic [7:0]  target_raw;
    logic        current_valid;
    logic [7:0]  cur_temp_raw;
    logic [7:0]  computed_sum;
    logic [7:0]  received_sum;
  } result_t;

endpackage

@@ sv/uart_status_frame_receiver.sv @@
`timescale 1ns / 1ps
// uart_status_frame_receiver: takes one received byte per beat, finds BB 00 04
// frames, checks their XOR checksum and reports one result beat per frame.
// Each record is queued, then loaded into the output register when that is free.
// Throughput: one byte per cycle; in_ready drops only while the record queue is full.
// Reset (rst_n low at a clock edge) clears the deframer, queue and output valid, and
// loads the configuration registers with their reset values.
module uart_status_frame_receiver #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_frame_kind,
  output logic       out_eco_on,
  output logic       out_turbo_on,
  output logic       out_quiet_on,
  output logic       out_target_valid,
  output logic [7:0] out_target_raw,
  output logic       out_current_valid,
  output logic [7:0] out_current_raw,
  output logic [7:0] out_computed_sum,
  output logic [7:0] out_received_sum,
  // configuration port
  input  logic                           cfg_we,
  input  logic [usfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);
  import usfr_pkg::*;

  frame_rec_t push_rec, head_rec;
  logic       q_push, q_full, q_pop, q_not_empty;
  result_t    res;

  // Front: track header, command, length and payload; push a record at the
  // checksum beat.
  usfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_rec      (push_rec)
  );

  // Queue: decouple the byte stream from a stalled result channel.
  usfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_rec  (push_rec),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_rec  (head_rec)
  );

  // Back: classify each record against the configuration and hold the
  // result until the beat is taken.
  usfr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_not_empty (q_not_empty),
    .q_head      (head_rec),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_res     (res)
  );

  assign out_frame_kind    = res.kind;
  assign out_eco_on        = res.eco_on;
  assign out_turbo_on      = res.turbo_flag;
  assign out_quiet_on      = res.quiet_flag;
  assign out_target_valid  = res.target_valid;
  assign out_target_raw    = res.target_raw;
  assign out_current_valid = res.current_valid;
  assign out_current_raw   = res.cur_temp_raw;
  assign out_computed_sum  = res.computed_sum;
  assign out_received_sum  = res.received_sum;

  // A checksum error is reported exactly when the sums differ.
  a_error_iff_mismatch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_frame_kind == KIND_ERROR) == (out_computed_sum != out_received_sum)))
    else $error("frame kind disagrees with checksum compare");

  // Status fields stay clear on anything but a status result.
  a_status_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_kind != KIND_STATUS) |->
      (!out_eco_on && !out_turbo_on && !out_quiet_on && !out_target_valid &&
       out_target_raw == 8'd0))
    else $error("status fields set on a non-status result");

  // Temperature fields stay clear on anything but a temperature result.
  a_temp_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_kind != KIND_TEMP) |->
      (!out_current_valid && out_current_raw == 8'd0))
    else $error("temperature fields set on a non-temperature result");

  // The validity flags follow their raw bytes.
  a_valid_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_frame_kind != KIND_STATUS ||
                    out_target_valid == (out_target_raw != 8'd0)) &&
                   (out_frame_kind != KIND_TEMP ||
                    out_current_valid == (out_current_raw > CURRENT_MIN_RAW))))
    else $error("validity flag does not match raw byte");

endmodule

@@ sv/usfr_front.sv @@
`timescale 1ns / 1ps
// usfr_front: header search and frame deframer; emits one record per frame.
// Depends on usfr_pkg.
module usfr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_rx_byte,
  input  logic                q_full,
  output logic                q_push,
  output usfr_pkg::frame_rec_t q_rec
);
  import usfr_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [1:0] hp_r, hp_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] mode_r, mode_nxt;
  logic [7:0] speed_r, speed_nxt;
  logic [7:0] target_r, target_nxt;
  logic [7:0] current_r, current_nxt;
  logic       beat;

  assign in_ready = !q_full;
  assign beat     = in_valid && in_ready;

  always_comb begin
    phase_nxt   = phase_r;
    hp_nxt      = hp_r;
    cmd_nxt     = cmd_r;
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    xor_nxt     = xor_r;
    mode_nxt    = mode_r;
    speed_nxt   = speed_r;
    target_nxt  = target_r;
    current_nxt = current_r;
    q_push      = 1'b0;
    if (beat) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (hp_r == 2'd1 && in_rx_byte == HDR1) begin
            hp_nxt = 2'd2;
          end else if (hp_r == 2'd2 && in_rx_byte == HDR2) begin
            hp_nxt    = 2'd0;
            phase_nxt = PH_CMD;
            xor_nxt   = HDR_XOR;
          end else begin
            // a stray BB restarts the match at length one
            hp_nxt = (in_rx_byte == HDR0) ? 2'd1 : 2'd0;
          end
        end
        PH_CMD: begin
          cmd_nxt   = in_rx_byte;
          xor_nxt   = xor_r ^ in_rx_byte;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          len_nxt   = in_rx_byte;
          xor_nxt   = xor_r ^ in_rx_byte;
          cnt_nxt   = 8'd0;
          phase_nxt = PH_PAY;
        end
        PH_PAY: begin
          if (cnt_r == len_r) begin
            q_push    = 1'b1;
            phase_nxt = PH_HUNT;
            hp_nxt    = 2'd0;
          end else begin
            if (cnt_r == POS_CURRENT) current_nxt = in_rx_byte;
            if (cnt_r == POS_MODE)    mode_nxt    = in_rx_byte;
            if (cnt_r == POS_SPEED)   speed_nxt   = in_rx_byte;
            if (cnt_r == POS_TARGET)  target_nxt  = in_rx_byte;
            xor_nxt = xor_r ^ in_rx_byte;
            cnt_nxt = cnt_r + 8'd1;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  always_comb begin
    q_rec.command      = cmd_r;
    q_rec.length       = len_r;
    q_rec.calc_sum     = xor_r;
    q_rec.rx_sum       = in_rx_byte;
    q_rec.mode_flags   = mode_r;
    q_rec.speed_flags  = speed_r;
    q_rec.target_byte  = target_r;
    q_rec.current_byte = current_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      hp_r      <= 2'd0;
      cmd_r     <= 8'd0;
      len_r     <= 8'd0;
      cnt_r     <= 8'd0;
      xor_r     <= 8'd0;
      mode_r    <= 8'd0;
      speed_r   <= 8'd0;
      target_r  <= 8'd0;
      current_r <= 8'd0;
    end else begin
      phase_r   <= phase_nxt;
      hp_r      <= hp_nxt;
      cmd_r     <= cmd_nxt;
      len_r     <= len_nxt;
      cnt_r     <= cnt_nxt;
      xor_r     <= xor_nxt;
      mode_r    <= mode_nxt;
      speed_r   <= speed_nxt;
      target_r  <= target_nxt;
      current_r <= current_nxt;
    end
  end

endmodule

@@ sv/usfr_queue.sv @@
`timescale 1ns / 1ps
// usfr_queue: short FIFO of frame records between the front and the back.
// Depends on usfr_pkg.
module usfr_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  usfr_pkg::frame_rec_t push_rec,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output usfr_pkg::frame_rec_t head_rec
);
  import usfr_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  frame_rec_t       slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_rec  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ sv/usfr_back.sv @@
`timescale 1ns / 1ps
// usfr_back: configuration registers, frame classification and output register.
// Depends on usfr_pkg.
module usfr_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [usfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          q_not_empty,
  input  usfr_pkg::frame_rec_t          q_head,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output usfr_pkg::result_t             out_res
);
  import usfr_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  result_t res_r, res_nxt;
  logic    out_valid_r, out_valid_nxt;

  assign q_pop     = q_not_empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_STATUS_CMD: cfg_nxt.status_cmd = cfg_data;
        CFG_TEMP_CMD:   cfg_nxt.temp_cmd   = cfg_data;
        CFG_ECO_MASK:   cfg_nxt.eco_mask   = cfg_data;
        CFG_TURBO_MASK: cfg_nxt.turbo_mask = cfg_data;
        CFG_QUIET_MASK: cfg_nxt.quiet_mask = cfg_data;
        default: ;
      endcase
    end
  end

  // Classify the head record; status wins over temperature on equal codes.
  always_comb begin
    res_nxt              = '0;
    res_nxt.computed_sum = q_head.calc_sum;
    res_nxt.received_sum = q_head.rx_sum;
    if (q_head.calc_sum != q_head.rx_sum) begin
      res_nxt.kind = KIND_ERROR;
    end else if (q_head.command == cfg_r.status_cmd) begin
      if (q_head.length >= STATUS_MIN_LEN) begin
        res_nxt.kind         = KIND_STATUS;
        res_nxt.eco_on       = |(q_head.mode_flags & cfg_r.eco_mask);
        res_nxt.turbo_flag   = |(q_head.speed_flags & cfg_r.turbo_mask);
        res_nxt.quiet_flag   = |(q_head.speed_flags & cfg_r.quiet_mask);
        res_nxt.target_valid = (q_head.target_byte != 8'd0);
        res_nxt.target_raw   = q_head.target_byte;
      end else begin
        res_nxt.kind = KIND_IGNORED;
      end
    end else if (q_head.command == cfg_r.temp_cmd) begin
      if (q_head.length >= TEMP_MIN_LEN) begin
        res_nxt.kind          = KIND_TEMP;
        res_nxt.current_valid = (q_head.current_byte > CURRENT_MIN_RAW);
        res_nxt.cur_temp_raw  = q_head.current_byte;
      end else begin
        res_nxt.kind = KIND_IGNORED;
      end
    end else begin
      res_nxt.kind = KIND_IGNORED;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.status_cmd <= 8'd0;
      cfg_r.temp_cmd   <= 8'd0;
      cfg_r.eco_mask   <= ECO_MASK_RST;
      cfg_r.turbo_mask <= TURBO_MASK_RST;
      cfg_r.quiet_mask <= QUIET_MASK_RST;
      out_valid_r      <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
